// ===== design/sha256_message_hasher_top_macros.svh =====
// Assertion macros shared by the SHA-256 message hasher RTL.
`ifndef SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`define SHA256_MESSAGE_HASHER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold on every clock edge outside reset.
`define SHA_MH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true on a clock edge outside reset.
`define SHA_MH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SHA_MH_ASSERT(lbl, prop, msg)
`define SHA_MH_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/sha_mh_pkg.sv =====
// Shared types and constants of the SHA-256 message hasher.
package sha_mh_pkg;

  localparam int unsigned COUNT_W    = 61;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned HASH_WORDS = 8;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_end;
  } sha_mh_in_t;

  // Output beat
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_mh_out_t;

  // Sequencer controls for the round datapath
  typedef struct packed {
    logic       hv_shift;  // shift a hash word into the working vars
    logic       hv_rot;    // rotate working vars during the final add
    logic       rnd_en;    // run one compression round
    logic       w_step;    // advance the schedule window, precompute K+W
    logic       w_mem;     // next schedule word comes from block memory
    logic [5:0] k_idx;     // round constant index for the precomputed K+W
  } sha_mh_ctl_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

// ===== design/sha_mh_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sha_mh_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sha_mh_round.sv =====
// SHA-256 round datapath: working variables, schedule window and K+W precompute.
module sha_mh_round import sha_mh_pkg::*; (
  input  logic        clk_i,
  input  sha_mh_ctl_t ctl_i,
  input  logic [31:0] hash_rd_i,
  input  logic [31:0] blk_rd_i,
  output logic [31:0] a_o
);

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  logic [31:0] v_q   [8];
  logic [31:0] win_q [BLK_WORDS];
  logic [31:0] kw_q;

  logic [31:0] big_s1, big_s0, ch, maj, t1, t2;
  logic [31:0] sml_s0, sml_s1, w_calc, w_next;

  // Round function, K+W already summed in kw_q
  always_comb begin
    big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big_s1 + ch + kw_q;
    big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2     = big_s0 + maj;
  end

  // Message expansion: window holds W[r-15..r] during round r
  always_comb begin
    sml_s0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    sml_s1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_calc = sml_s1 + win_q[9] + sml_s0 + win_q[0];
    w_next = ctl_i.w_mem ? blk_rd_i : w_calc;
  end

  // Working variables
  always_ff @(posedge clk_i) begin
    priority if (ctl_i.rnd_en) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (ctl_i.hv_shift) begin
      for (int i = 0; i < 7; i++) begin
        v_q[i] <= v_q[i+1];
      end
      v_q[7] <= hash_rd_i;
    end else if (ctl_i.hv_rot) begin
      for (int i = 0; i < 7; i++) begin
        v_q[i] <= v_q[i+1];
      end
      v_q[7] <= v_q[0];
    end
  end

  // Schedule window and next K+W
  always_ff @(posedge clk_i) begin
    if (ctl_i.w_step) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[BLK_WORDS-1] <= w_next;
      kw_q <= ROUND_K[ctl_i.k_idx] + w_next;
    end
  end

  assign a_o = v_q[0];

endmodule

// ===== design/sha256_message_hasher_top.sv =====
// SHA-256 message hasher top: byte intake, padding, block sequencer and digest output.
// A byte beat is taken in S_IDLE; a beat that fills a 64-byte block then runs the block
// (8+1 hash-word loads, 64 rounds at one per cycle, 8+1 hash-memory updates).
// An end beat adds a pad start and up to 18 pad-word writes, one or two such blocks,
// then 8 digest beats, each a hash memory read, then an output register write.
// Async active-low reset: hash words read as initial values, length zero, no sweep.
`include "sha256_message_hasher_top_macros.svh"

module sha256_message_hasher_top import sha_mh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sha_mh_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sha_mh_out_t out_data_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PSTART  = 3'd1;
  localparam logic [2:0] S_PAD     = 3'd2;
  localparam logic [2:0] S_LOAD    = 3'd3;
  localparam logic [2:0] S_ROUND   = 3'd4;
  localparam logic [2:0] S_ADD     = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;
  localparam logic [2:0] S_EMIT_WR = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [23:0]        acc_q, acc_d;
  logic               fresh_q, fresh_d;
  logic               end_pend_q, end_pend_d;
  logic               pad2_q, pad2_d;
  logic               digest_q, digest_d;
  logic               pad_two_q, pad_two_d;
  logic               pad_first_q, pad_first_d;
  logic               out_valid_q, out_valid_d;
  sha_mh_out_t        out_q, out_d;

  logic        in_fire;
  logic        blk_busy;
  logic [5:0]  byte_pos;
  logic [31:0] pad_word;
  logic [63:0] len_bits;

  logic        blk_we;
  logic [3:0]  blk_waddr, blk_raddr;
  logic [31:0] blk_wdata, blk_rd;

  logic        hash_we;
  logic [2:0]  hash_waddr, hash_raddr, hash_raddr_q;
  logic [31:0] hash_wdata, hash_ram_rd, hash_rd;

  sha_mh_ctl_t ctl;
  logic [31:0] a_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign byte_pos   = count_q[5:0];
  assign len_bits   = {count_q, 3'b000};

  // First pad word: partial bytes, then the 0x80 marker
  always_comb begin
    unique case (count_q[1:0])
      2'd0: pad_word = {PAD_BYTE, 24'h0};
      2'd1: pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
      2'd2: pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
      2'd3: pad_word = {acc_q, PAD_BYTE};
    endcase
  end

  // Memory read addresses follow the step counter
  assign hash_raddr = cnt_q[2:0];
  always_comb begin
    if (state_q == S_LOAD) begin
      blk_raddr = (cnt_q == 6'd8) ? 4'd1 : 4'd0;
    end else begin
      blk_raddr = cnt_q[3:0] + 4'd2;
    end
  end

  // Hash words read as initial values until a block writes them back
  assign hash_rd = fresh_q ? HASH_IV[hash_raddr_q] : hash_ram_rd;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    acc_d       = acc_q;
    fresh_d     = fresh_q;
    end_pend_d  = end_pend_q;
    pad2_d      = pad2_q;
    digest_d    = digest_q;
    pad_two_d   = pad_two_q;
    pad_first_d = pad_first_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    blk_we      = 1'b0;
    blk_waddr   = cnt_q[3:0];
    blk_wdata   = 32'h0;
    hash_we     = 1'b0;
    hash_waddr  = 3'(cnt_q - 6'd1);
    hash_wdata  = hash_rd + a_val;
    ctl         = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.has_byte) begin
            acc_d   = {acc_q[15:0], in_data_i.data_byte};
            count_d = count_q + COUNT_W'(1);
            if (byte_pos[1:0] == 2'b11) begin
              blk_we    = 1'b1;
              blk_waddr = byte_pos[5:2];
              blk_wdata = {acc_q, in_data_i.data_byte};
            end
            if (byte_pos == 6'd63) begin
              state_d    = S_LOAD;
              cnt_d      = 6'd0;
              end_pend_d = in_data_i.is_end;
            end else if (in_data_i.is_end) begin
              state_d = S_PSTART;
            end
          end else if (in_data_i.is_end) begin
            state_d = S_PSTART;
          end
        end
      end
      S_PSTART: begin
        cnt_d       = {2'b00, byte_pos[5:2]};
        pad_two_d   = &byte_pos[5:3];
        pad_first_d = 1'b1;
        state_d     = S_PAD;
      end
      S_PAD: begin
        blk_we    = 1'b1;
        blk_waddr = cnt_q[3:0];
        priority if (pad_first_q) begin
          blk_wdata = pad_word;
        end else if (!pad_two_q && cnt_q[3:0] == 4'd14) begin
          blk_wdata = len_bits[63:32];
        end else if (!pad_two_q && cnt_q[3:0] == 4'd15) begin
          blk_wdata = len_bits[31:0];
        end else begin
          blk_wdata = 32'h0;
        end
        pad_first_d = 1'b0;
        if (cnt_q[3:0] == 4'd15) begin
          state_d = S_LOAD;
          cnt_d   = 6'd0;
          if (pad_two_q) begin
            pad2_d = 1'b1;
          end else begin
            digest_d = 1'b1;
            count_d  = '0;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_LOAD: begin
        ctl.hv_shift = (cnt_q != 6'd0);
        if (cnt_q == 6'd8) begin
          ctl.w_step = 1'b1;
          ctl.w_mem  = 1'b1;
          ctl.k_idx  = 6'd0;
          state_d    = S_ROUND;
          cnt_d      = 6'd0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_ROUND: begin
        ctl.rnd_en = 1'b1;
        ctl.w_step = 1'b1;
        ctl.w_mem  = (cnt_q < 6'd15);
        ctl.k_idx  = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_ADD;
          cnt_d   = 6'd0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_ADD: begin
        if (cnt_q != 6'd0) begin
          hash_we    = 1'b1;
          ctl.hv_rot = 1'b1;
        end
        if (cnt_q == 6'd8) begin
          fresh_d = 1'b0;
          cnt_d   = 6'd0;
          priority if (pad2_q) begin
            pad2_d      = 1'b0;
            pad_two_d   = 1'b0;
            pad_first_d = 1'b0;
            state_d     = S_PAD;
          end else if (end_pend_q) begin
            end_pend_d = 1'b0;
            state_d    = S_PSTART;
          end else if (digest_q) begin
            digest_d = 1'b0;
            state_d  = S_EMIT_RD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_EMIT_RD: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_EMIT_WR;
        end
      end
      S_EMIT_WR: begin
        out_d.digest_word = hash_rd;
        out_d.word_index  = cnt_q[2:0];
        out_d.last_word   = (cnt_q[2:0] == 3'd7);
        out_valid_d       = 1'b1;
        if (cnt_q[2:0] == 3'd7) begin
          fresh_d = 1'b1;
          cnt_d   = 6'd0;
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 6'd1;
          state_d = S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 6'd0;
      count_q     <= '0;
      fresh_q     <= 1'b1;
      end_pend_q  <= 1'b0;
      pad2_q      <= 1'b0;
      digest_q    <= 1'b0;
      pad_two_q   <= 1'b0;
      pad_first_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      end_pend_q  <= end_pend_d;
      pad2_q      <= pad2_d;
      digest_q    <= digest_d;
      pad_two_q   <= pad_two_d;
      pad_first_q <= pad_first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    out_q        <= out_d;
    hash_raddr_q <= hash_raddr;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Message block words, later the first 16 schedule words
  sha_mh_ram #(.Width(32), .Depth(BLK_WORDS)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rd)
  );

  // Chaining hash words
  sha_mh_ram #(.Width(32), .Depth(HASH_WORDS)) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (hash_we),
    .waddr_i (hash_waddr),
    .wdata_i (hash_wdata),
    .raddr_i (hash_raddr),
    .rdata_o (hash_ram_rd)
  );

  sha_mh_round u_round (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .hash_rd_i (hash_rd),
    .blk_rd_i  (blk_rd),
    .a_o       (a_val)
  );

  // Checks
  assign blk_busy = (state_q == S_LOAD) || (state_q == S_ROUND);

  `SHA_MH_ASSERT(a_emit_slot_free, state_q == S_EMIT_WR |-> !out_valid_q, "digest beat lost")
  `SHA_MH_ASSERT_NEVER(a_blk_quiet, blk_busy && blk_we, "block memory written in rounds")
  `SHA_MH_ASSERT(a_hash_rw_split, hash_we |-> hash_waddr != hash_raddr, "hash access clash")
  `SHA_MH_ASSERT(a_fresh_emit, $rose(fresh_q) |-> $past(state_q) == S_EMIT_WR, "stray hash reset")

endmodule
